### rtl/machine_home_reset_sequencer_macros.svh
// Assertion macros used by the homing sequencer checker.
`ifndef MACHINE_HOME_RESET_SEQUENCER_MACROS_SVH
`define MACHINE_HOME_RESET_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MHRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhrs assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define MHRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhrs assertion failed");

`endif

### rtl/mhrs_pkg.sv
// Types and constants shared by the homing sequencer modules.
package mhrs_pkg;

  localparam int NUM_ACTUATORS = 16;
  localparam int ACT_IDX_W = $clog2(NUM_ACTUATORS);
  localparam int LIMIT_BITS = 23;
  localparam int LIM_IDX_W = $clog2(LIMIT_BITS);
  localparam int STEP_W = 5;
  localparam int ADDR_W = 4;

  localparam logic [15:0] ALARM_DEFAULT_MS = 16'd2000;

  localparam logic [1:0] CMD_SCAN = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [1:0] ABORT_NONE = 2'd0;
  localparam logic [1:0] ABORT_GATE = 2'd1;
  localparam logic [1:0] ABORT_ALL = 2'd2;

  localparam logic [1:0] REG_ALARM = 2'd0;
  localparam logic [1:0] REG_XFER_EL = 2'd1;
  localparam logic [1:0] REG_UD_EL = 2'd2;

  localparam logic [STEP_W-1:0] S_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] S_BPIN_WAIT = 5'd1;
  localparam logic [STEP_W-1:0] S_LIFT_WAIT = 5'd2;
  localparam logic [STEP_W-1:0] S_TDF_OC_CHK = 5'd3;
  localparam logic [STEP_W-1:0] S_TDF_OC_WAIT = 5'd4;
  localparam logic [STEP_W-1:0] S_TDF_CHK = 5'd5;
  localparam logic [STEP_W-1:0] S_TDF_WAIT = 5'd6;
  localparam logic [STEP_W-1:0] S_BDF_CHK = 5'd7;
  localparam logic [STEP_W-1:0] S_BDF_WAIT = 5'd8;
  localparam logic [STEP_W-1:0] S_COOL_START = 5'd9;
  localparam logic [STEP_W-1:0] S_COOL_WAIT = 5'd10;
  localparam logic [STEP_W-1:0] S_HOOK_CHK = 5'd11;
  localparam logic [STEP_W-1:0] S_HOOK_WAIT = 5'd12;
  localparam logic [STEP_W-1:0] S_CLAMP_CHK = 5'd13;
  localparam logic [STEP_W-1:0] S_CLAMP_WAIT = 5'd14;
  localparam logic [STEP_W-1:0] S_CLAMP2_CHK = 5'd15;
  localparam logic [STEP_W-1:0] S_CLAMP2_WAIT = 5'd16;
  localparam logic [STEP_W-1:0] S_SUB_START = 5'd17;
  localparam logic [STEP_W-1:0] S_SUB_WAIT = 5'd18;
  localparam logic [STEP_W-1:0] S_XFER_CHK = 5'd19;
  localparam logic [STEP_W-1:0] S_XFER_WAIT = 5'd20;
  localparam logic [STEP_W-1:0] S_ROBOT_CHK = 5'd21;
  localparam logic [STEP_W-1:0] S_ROBOT_WAIT = 5'd22;
  localparam logic [STEP_W-1:0] S_CARR_CHK = 5'd23;
  localparam logic [STEP_W-1:0] S_CARR_WAIT = 5'd24;
  localparam logic [STEP_W-1:0] S_SKIP_WAIT = 5'd25;
  localparam logic [STEP_W-1:0] S_BPDN_CHK = 5'd26;
  localparam logic [STEP_W-1:0] S_BPDN_WAIT = 5'd27;
  localparam logic [STEP_W-1:0] S_DONE = 5'd28;
  localparam logic [STEP_W-1:0] S_FINISHED = 5'd29;
  localparam logic [STEP_W-1:0] S_STOPALL = 5'd30;
  localparam logic [STEP_W-1:0] S_FAULTED = 5'd31;

  localparam logic [ACT_IDX_W-1:0] A_BPIN = 4'd0;
  localparam logic [ACT_IDX_W-1:0] A_BPIN2 = 4'd1;
  localparam logic [ACT_IDX_W-1:0] A_LIFT = 4'd2;
  localparam logic [ACT_IDX_W-1:0] A_TDF_OC = 4'd3;
  localparam logic [ACT_IDX_W-1:0] A_TDF = 4'd4;
  localparam logic [ACT_IDX_W-1:0] A_BDF = 4'd5;
  localparam logic [ACT_IDX_W-1:0] A_COOL1 = 4'd6;
  localparam logic [ACT_IDX_W-1:0] A_COOL2 = 4'd7;
  localparam logic [ACT_IDX_W-1:0] A_COOL3 = 4'd8;
  localparam logic [ACT_IDX_W-1:0] A_HOOK = 4'd9;
  localparam logic [ACT_IDX_W-1:0] A_CLAMP = 4'd10;
  localparam logic [ACT_IDX_W-1:0] A_SUB = 4'd11;
  localparam logic [ACT_IDX_W-1:0] A_BSUB = 4'd12;
  localparam logic [ACT_IDX_W-1:0] A_XFER = 4'd13;
  localparam logic [ACT_IDX_W-1:0] A_ROBOT = 4'd14;
  localparam logic [ACT_IDX_W-1:0] A_CARR = 4'd15;

  localparam logic [LIM_IDX_W-1:0] L_CARR_BACK = 5'd0;
  localparam logic [LIM_IDX_W-1:0] L_CLAMP_OPEN = 5'd1;
  localparam logic [LIM_IDX_W-1:0] L_TDF_BACK = 5'd5;
  localparam logic [LIM_IDX_W-1:0] L_BDF_BACK = 5'd6;
  localparam logic [LIM_IDX_W-1:0] L_TDF_OPEN = 5'd7;
  localparam logic [LIM_IDX_W-1:0] L_ROBOT_OPEN = 5'd10;
  localparam logic [LIM_IDX_W-1:0] L_HOOK_BACK = 5'd13;
  localparam logic [LIM_IDX_W-1:0] L_XFER_BACK = 5'd14;
  localparam logic [LIM_IDX_W-1:0] L_XFER_CAL = 5'd15;
  localparam logic [LIM_IDX_W-1:0] L_UD_UP = 5'd16;
  localparam logic [LIM_IDX_W-1:0] L_UD_CAL = 5'd17;
  localparam logic [LIM_IDX_W-1:0] L_BPIN_UP = 5'd18;
  localparam logic [LIM_IDX_W-1:0] L_BPIN2_UP = 5'd19;
  localparam logic [LIM_IDX_W-1:0] L_BPIN_DN = 5'd20;
  localparam logic [LIM_IDX_W-1:0] L_BPIN2_DN = 5'd21;

  typedef struct packed {
    logic [1:0]               command;
    logic                     safe_gate_closed;
    logic [LIMIT_BITS-1:0]    limit_switches;
    logic [NUM_ACTUATORS-1:0] actuator_done;
    logic [NUM_ACTUATORS-1:0] actuator_fault;
    logic                     tick;
  } scan_t;

  typedef struct packed {
    logic [STEP_W-1:0]        seq_state;
    logic [NUM_ACTUATORS-1:0] start_mask;
    logic [NUM_ACTUATORS-1:0] clear_mask;
    logic [1:0]               abort_kind;
    logic                     aux_clamp_off;
    logic                     timer_running;
    logic [15:0]              elapsed_ms;
    logic                     finished;
    logic                     faulted;
  } result_t;

  typedef struct packed {
    logic [15:0] alarm_time_ms;
    logic        transfer_is_electric;
    logic        updown_is_electric;
  } cfg_t;

endpackage

### rtl/mhrs_step.sv
// Next-state and output logic of the homing sequencer for one scan.
module mhrs_step #(
  parameter int TIMER_BITS = 16
) (
  input  mhrs_pkg::scan_t                 scan,
  input  mhrs_pkg::cfg_t                  cfg,
  input  logic [mhrs_pkg::STEP_W-1:0]     step,
  input  logic [TIMER_BITS-1:0]           watch_count,
  input  logic                            watch_enable,
  output logic [mhrs_pkg::STEP_W-1:0]     step_next,
  output logic [TIMER_BITS-1:0]           watch_count_next,
  output logic                            watch_enable_next,
  output mhrs_pkg::result_t               result
);
  import mhrs_pkg::*;

  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_WAIT = 2'd1;
  localparam logic [1:0] M_EACH = 2'd2;
  localparam logic [1:0] M_CHECK = 2'd3;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;
  localparam logic [32:0] TMAX_W = (33'd1 << TIMER_BITS) - 33'd1;

  logic [STEP_W-1:0]        nxt;
  logic [NUM_ACTUATORS-1:0] startm;
  logic [NUM_ACTUATORS-1:0] clearm;
  logic [NUM_ACTUATORS-1:0] dn;
  logic [NUM_ACTUATORS-1:0] ft;
  logic [LIMIT_BITS-1:0]    sw;
  logic [1:0]               abort_kind;
  logic                     aux;
  logic                     en;
  logic [TIMER_BITS-1:0]    cnt;
  logic                     running;
  logic                     skip;
  logic [1:0]               mode;
  logic [NUM_ACTUATORS-1:0] wset;
  logic [STEP_W-1:0]        wnext;
  logic [LIM_IDX_W-1:0]     cbit;
  logic [ACT_IDX_W-1:0]     cact;
  logic [STEP_W-1:0]        cwait;
  logic [STEP_W-1:0]        cskip;
  logic [32:0]              limit_w;
  logic [32:0]              cnt_w;

  assign sw = scan.limit_switches;
  assign dn = scan.actuator_done;
  assign ft = scan.actuator_fault;
  assign running = (step >= S_BPIN_WAIT) && (step <= S_DONE);

  always_comb begin
    limit_w = (cfg.alarm_time_ms == 16'd0) ? 33'(ALARM_DEFAULT_MS) : 33'(cfg.alarm_time_ms);
    if (limit_w > TMAX_W) begin
      limit_w = TMAX_W;
    end
  end

  always_comb begin
    nxt = step;
    startm = '0;
    clearm = '0;
    abort_kind = ABORT_NONE;
    aux = 1'b0;
    en = watch_enable;
    cnt = watch_count;
    mode = M_NONE;
    wset = '0;
    wnext = step;
    cbit = L_CARR_BACK;
    cact = A_BPIN;
    cwait = step;
    cskip = step;
    skip = 1'b0;

    if (scan.command == CMD_CANCEL) begin
      nxt = S_IDLE;
      en = 1'b0;
      cnt = '0;
    end else if (scan.command == CMD_START) begin
      cnt = '0;
    end else if (!scan.safe_gate_closed && running) begin
      abort_kind = ABORT_GATE;
      en = 1'b0;
      nxt = S_IDLE;
    end else begin
      case (step)
        S_BPIN_WAIT: begin
          mode = M_EACH; wset[A_BPIN] = 1'b1; wset[A_BPIN2] = 1'b1; wnext = S_LIFT_WAIT;
        end
        S_LIFT_WAIT: begin
          mode = M_WAIT; wset[A_LIFT] = 1'b1; wnext = S_TDF_OC_CHK;
        end
        S_TDF_OC_CHK: begin
          mode = M_CHECK; cbit = L_TDF_OPEN; cact = A_TDF_OC;
          cwait = S_TDF_OC_WAIT; cskip = S_TDF_CHK;
        end
        S_TDF_OC_WAIT: begin
          mode = M_WAIT; wset[A_TDF_OC] = 1'b1; wnext = S_TDF_CHK;
        end
        S_TDF_CHK: begin
          mode = M_CHECK; cbit = L_TDF_BACK; cact = A_TDF;
          cwait = S_TDF_WAIT; cskip = S_BDF_CHK;
        end
        S_TDF_WAIT: begin
          mode = M_WAIT; wset[A_TDF] = 1'b1; wnext = S_BDF_CHK;
        end
        S_BDF_CHK: begin
          mode = M_CHECK; cbit = L_BDF_BACK; cact = A_BDF;
          cwait = S_BDF_WAIT; cskip = S_COOL_START;
        end
        S_BDF_WAIT: begin
          mode = M_WAIT; wset[A_BDF] = 1'b1; wnext = S_COOL_START;
        end
        S_COOL_START: begin
          startm[A_COOL1] = 1'b1; startm[A_COOL2] = 1'b1; startm[A_COOL3] = 1'b1;
          nxt = S_COOL_WAIT;
        end
        S_COOL_WAIT: begin
          mode = M_WAIT; wset[A_COOL1] = 1'b1; wset[A_COOL2] = 1'b1;
          wset[A_COOL3] = 1'b1; wnext = S_HOOK_CHK;
        end
        S_HOOK_CHK: begin
          mode = M_CHECK; cbit = L_HOOK_BACK; cact = A_HOOK;
          cwait = S_HOOK_WAIT; cskip = S_CLAMP_CHK;
        end
        S_HOOK_WAIT: begin
          mode = M_WAIT; wset[A_HOOK] = 1'b1; wnext = S_CLAMP_CHK;
        end
        S_CLAMP_CHK: begin
          mode = M_CHECK; cbit = L_CLAMP_OPEN; cact = A_CLAMP;
          cwait = S_CLAMP_WAIT; cskip = S_SUB_START;
        end
        S_CLAMP_WAIT: begin
          mode = M_WAIT; wset[A_CLAMP] = 1'b1; wnext = S_CLAMP2_CHK;
        end
        S_CLAMP2_CHK: begin
          mode = M_CHECK; cbit = L_CLAMP_OPEN; cact = A_CLAMP;
          cwait = S_CLAMP2_WAIT; cskip = S_XFER_CHK;
        end
        S_CLAMP2_WAIT: begin
          mode = M_WAIT; wset[A_CLAMP] = 1'b1; wnext = S_SUB_START;
        end
        S_SUB_START: begin
          startm[A_SUB] = 1'b1; startm[A_BSUB] = 1'b1;
          nxt = S_SUB_WAIT;
        end
        S_SUB_WAIT: begin
          mode = M_WAIT; wset[A_SUB] = 1'b1; wset[A_BSUB] = 1'b1; wnext = S_XFER_CHK;
        end
        S_XFER_CHK: begin
          mode = M_CHECK; cbit = L_XFER_BACK; cact = A_XFER;
          cwait = S_XFER_WAIT; cskip = S_ROBOT_CHK;
        end
        S_XFER_WAIT: begin
          mode = M_WAIT; wset[A_XFER] = 1'b1; wnext = S_ROBOT_CHK;
        end
        S_ROBOT_CHK: begin
          mode = M_CHECK; cbit = L_ROBOT_OPEN; cact = A_ROBOT;
          cwait = S_ROBOT_WAIT; cskip = S_CARR_CHK;
        end
        S_ROBOT_WAIT: begin
          mode = M_WAIT; wset[A_ROBOT] = 1'b1; wnext = S_CARR_CHK;
        end
        S_CARR_CHK: begin
          mode = M_CHECK; cbit = L_CARR_BACK; cact = A_CARR;
          cwait = S_CARR_WAIT; cskip = S_BPDN_CHK;
        end
        S_CARR_WAIT: begin
          mode = M_WAIT; wset[A_CARR] = 1'b1; wnext = S_BPDN_CHK;
        end
        S_SKIP_WAIT: begin
          mode = M_WAIT; wset[A_LIFT] = 1'b1; wnext = S_BPDN_CHK;
        end
        S_BPDN_CHK: begin
          if (!sw[L_BPIN_DN] || !sw[L_BPIN2_DN]) begin
            startm[A_BPIN] = 1'b1; startm[A_BPIN2] = 1'b1;
            nxt = S_BPDN_WAIT;
          end else begin
            nxt = S_DONE;
          end
        end
        S_BPDN_WAIT: begin
          mode = M_EACH; wset[A_BPIN] = 1'b1; wset[A_BPIN2] = 1'b1; wnext = S_DONE;
        end
        S_DONE: begin
          en = 1'b0;
          nxt = S_FINISHED;
        end
        S_STOPALL: begin
          en = 1'b0;
          abort_kind = ABORT_ALL;
          nxt = S_FAULTED;
        end
        default: begin
        end
      endcase
    end

    case (mode)
      M_CHECK: begin
        if (!sw[cbit]) begin
          startm[cact] = 1'b1;
          nxt = cwait;
        end else begin
          nxt = cskip;
        end
      end
      M_WAIT, M_EACH: begin
        if ((dn & wset) == wset) begin
          clearm = clearm | wset;
          nxt = wnext;
        end
        if ((ft & wset) != '0) begin
          clearm = clearm | ((mode == M_EACH) ? (ft & wset) : wset);
          nxt = S_STOPALL;
        end
      end
      default: begin
      end
    endcase

    if (scan.command == CMD_START) begin
      en = 1'b1;
      aux = 1'b1;
      startm[A_LIFT] = 1'b1;
      skip = (&sw[L_XFER_BACK:L_CARR_BACK])
             && (sw[L_XFER_CAL] || !cfg.transfer_is_electric)
             && sw[L_UD_UP]
             && (sw[L_UD_CAL] || !cfg.updown_is_electric);
      if (skip) begin
        nxt = S_SKIP_WAIT;
      end else if (!sw[L_BPIN_UP] || !sw[L_BPIN2_UP]) begin
        startm[A_BPIN] = 1'b1; startm[A_BPIN2] = 1'b1;
        nxt = S_BPIN_WAIT;
      end else begin
        nxt = S_LIFT_WAIT;
      end
    end

    if (en) begin
      if (scan.tick && (cnt != TMAX)) begin
        cnt = cnt + 1'b1;
      end
    end else begin
      cnt = '0;
    end
    cnt_w = 33'(cnt);
    if (en && (cnt_w >= limit_w)) begin
      en = 1'b0;
      nxt = S_STOPALL;
    end
  end

  assign step_next = nxt;
  assign watch_count_next = cnt;
  assign watch_enable_next = en;

  always_comb begin
    result.seq_state = nxt;
    result.start_mask = startm;
    result.clear_mask = clearm;
    result.abort_kind = abort_kind;
    result.aux_clamp_off = aux;
    result.timer_running = en;
    result.elapsed_ms = cnt_w[15:0];
    result.finished = (nxt == S_FINISHED);
    result.faulted = (nxt == S_STOPALL) || (nxt == S_FAULTED);
  end

endmodule

### rtl/machine_home_reset_sequencer.sv
// Homing sequencer top level: request register, sequence state, result register, APB registers.
// One scan request is taken every clock while scan_stall is low; a request is captured in the
// request register, and the next-state logic loads its result from there into the result
// register. The sequence state, watchdog count and enable update once per scan, in the same
// cycle that the result register loads, so the throughput is one scan per clock when no
// result stall holds the result register.
// A stalled result holds the result register and, once the request register is also
// full, raises scan_stall. Registers: alarm_time_ms at 0x0, transfer_is_electric at
// 0x4, updown_is_electric at 0x8; write them only while no scan is in flight.
module machine_home_reset_sequencer #(
  parameter int TIMER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mhrs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          scan_valid,
  output logic                          scan_stall,
  input  mhrs_pkg::scan_t               scan,
  output logic                          result_valid,
  input  logic                          result_stall,
  output mhrs_pkg::result_t             result
);
  import mhrs_pkg::*;

  cfg_t                  cfg;
  scan_t                 scan_q;
  logic                  scan_q_valid;
  logic [STEP_W-1:0]     step;
  logic [STEP_W-1:0]     step_next;
  logic [TIMER_BITS-1:0] watch_count;
  logic [TIMER_BITS-1:0] watch_count_next;
  logic                  watch_enable;
  logic                  watch_enable_next;
  result_t               result_next;
  logic                  out_free;
  logic                  advance;
  logic                  cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign out_free = !result_valid || !result_stall;
  assign advance = scan_q_valid && out_free;
  assign scan_stall = scan_q_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_time_ms <= ALARM_DEFAULT_MS;
      cfg.transfer_is_electric <= 1'b0;
      cfg.updown_is_electric <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ALARM: cfg.alarm_time_ms <= pwdata[15:0];
        REG_XFER_EL: cfg.transfer_is_electric <= pwdata[0];
        REG_UD_EL: cfg.updown_is_electric <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALARM: prdata = {16'd0, cfg.alarm_time_ms};
      REG_XFER_EL: prdata = {31'd0, cfg.transfer_is_electric};
      REG_UD_EL: prdata = {31'd0, cfg.updown_is_electric};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_q_valid <= 1'b0;
    end else if (!scan_stall) begin
      scan_q_valid <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!scan_stall && scan_valid) begin
      scan_q <= scan;
    end
  end

  mhrs_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .scan             (scan_q),
    .cfg              (cfg),
    .step             (step),
    .watch_count      (watch_count),
    .watch_enable     (watch_enable),
    .step_next        (step_next),
    .watch_count_next (watch_count_next),
    .watch_enable_next(watch_enable_next),
    .result           (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
      watch_count <= '0;
      watch_enable <= 1'b0;
    end else if (advance) begin
      step <= step_next;
      watch_count <= watch_count_next;
      watch_enable <= watch_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= scan_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

### rtl/mhrs_checker.sv
// Port-level checker for the homing sequencer and its bind to the top level.
`include "machine_home_reset_sequencer_macros.svh"

module mhrs_checker (
  input logic              clk,
  input logic              rst,
  input logic              scan_stall,
  input logic              result_valid,
  input logic              result_stall,
  input mhrs_pkg::result_t result
);
  import mhrs_pkg::*;

  `MHRS_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
  `MHRS_ASSERT_IMP(a_stall_needs_result, scan_stall, result_valid && result_stall)
  `MHRS_ASSERT_IMP(a_stop_all_faults, result_valid && (result.abort_kind == ABORT_ALL), result.seq_state == S_FAULTED && !result.timer_running)
  `MHRS_ASSERT_IMP(a_start_moves_lift, result_valid && result.aux_clamp_off, result.start_mask[A_LIFT])
  `MHRS_ASSERT_IMP(a_fault_hold_quiet, result_valid && (result.seq_state == S_FAULTED), result.faulted && !result.timer_running && !result.finished)

endmodule

bind machine_home_reset_sequencer mhrs_checker u_mhrs_checker (
  .clk         (clk),
  .rst         (rst),
  .scan_stall  (scan_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);
